### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by tcw_front, tcw_back and text_console_writer; no dependencies.
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths
  localparam int MODE_W      = 2;
  localparam int CODE_W      = 8;
  localparam int IDX_W       = 11;
  localparam int POS_W       = 11;
  localparam int CELL_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 1;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Character codes
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CODE_SPACE     = 8'h20;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_ATTR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;
  localparam logic [ATTR_W-1:0]    RESET_CHAR_ATTR  = 8'h0A;
  localparam logic [ATTR_W-1:0]    RESET_BLANK_ATTR = 8'h07;
  localparam logic [CELL_W-1:0]    RESET_BLANK = {RESET_BLANK_ATTR, CODE_SPACE};

  // Command queue depth between front and back
  localparam int QDEPTH = 2;

  // Classified command
  typedef enum logic [2:0] {
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_PRINT,
    KIND_CLEAR,
    KIND_READ,
    KIND_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  index;
    logic              idx_ok;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_PRIME,
    BK_SWEEP,
    BK_PUT
  } bk_state_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic init;
    logic take;
    logic sweep;
  } bk_stat_t;

endpackage

### rtl/core/tcw_front.sv
// Front end: accepts input transfers, classifies them into commands and
// holds them in a short queue for the back end. Depends on tcw_pkg.
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output tcw_pkg::cmd_t                     cmd
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  logic [MODE_W-1:0] mode;
  logic [CODE_W-1:0] code;
  logic [IDX_W-1:0]  index;
  cmd_t              cls;

  cmd_t              q_r [QDEPTH];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push, pop;

  // Unpack the transfer
  assign mode  = in_tdata[MODE_W-1:0];
  assign code  = in_tdata[MODE_W+CODE_W-1:MODE_W];
  assign index = in_tdata[MODE_W+CODE_W+IDX_W-1:MODE_W+CODE_W];

  // Classify
  always_comb begin
    cls.code   = code;
    cls.index  = index;
    cls.idx_ok = (32'(index) < 32'(CELLS));
    unique case (mode)
      MODE_PUT: begin
        if (code == CODE_NEWLINE) cls.kind = KIND_NEWLINE;
        else if (code == CODE_BACKSPACE) cls.kind = KIND_BACKSPACE;
        else cls.kind = KIND_PRINT;
      end
      MODE_CLEAR: cls.kind = KIND_CLEAR;
      MODE_READ:  cls.kind = KIND_READ;
      default:    cls.kind = KIND_NOP;
    endcase
  end

  // Queue control
  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule

### rtl/core/tcw_back.sv
// Back end: cell store, cursor and the sequencer that prints, scrolls,
// clears and reads; drives the result register. Depends on tcw_pkg.
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  tcw_pkg::cmd_t                     cmd,
  input  logic [tcw_pkg::ATTR_W-1:0]        char_attr,
  input  logic [tcw_pkg::ATTR_W-1:0]        blank_attr,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output tcw_pkg::bk_stat_t                 stat
);
  import tcw_pkg::*;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int AW        = $clog2(CELLS);
  localparam int PW        = $clog2(CELLS + 1);
  localparam int RW        = $clog2(ROWS);
  localparam int CW        = $clog2(COLUMNS + 1);
  localparam int COPY_LAST = CELLS - COLUMNS - 1;

  // Cell store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              we, rd_en;
  logic [AW-1:0]     wa, ra;
  logic [CELL_W-1:0] wd;

  bk_state_t         st_r, st_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  cmd_t              cmd_r;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0] out_val_r, out_val_nxt;

  logic              take, emit, scrolling, last_ptr;
  logic [CELL_W-1:0] blank, glyph_now, glyph_held;
  logic [PW-1:0]     pos_nxt;

  assign blank      = {blank_attr, CODE_SPACE};
  assign glyph_now  = {char_attr, cmd.code};
  assign glyph_held = {char_attr, cmd_r.code};
  assign cmd_ready  = (st_r == BK_IDLE) && (!out_valid_r || out_tready);
  assign take       = cmd_valid && cmd_ready;
  assign scrolling  = (cmd_r.kind != KIND_CLEAR);
  assign last_ptr   = (ptr_r == AW'(CELLS - 1));
  assign pos_nxt    = PW'(base_nxt) + PW'(col_nxt);

  // Sequencer: next state, cursor, store access and result
  always_comb begin
    st_nxt        = st_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    ptr_nxt       = ptr_r;
    src_nxt       = src_r;
    we            = 1'b0;
    wa            = ptr_r;
    wd            = blank;
    rd_en         = 1'b0;
    ra            = src_r;
    emit          = 1'b0;
    out_val_nxt   = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (st_r)
      BK_INIT: begin
        we      = 1'b1;
        wd      = RESET_BLANK;
        ptr_nxt = ptr_r + AW'(1);
        if (last_ptr) st_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            KIND_NEWLINE: begin
              col_nxt = '0;
              if (row_r == RW'(ROWS - 1)) begin
                st_nxt = BK_PRIME;
              end else begin
                row_nxt  = row_r + RW'(1);
                base_nxt = base_r + AW'(COLUMNS);
                emit     = 1'b1;
              end
            end
            KIND_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - CW'(1);
                we      = 1'b1;
                wa      = base_r + AW'(col_r - CW'(1));
              end
              emit = 1'b1;
            end
            KIND_PRINT: begin
              if (col_r == CW'(COLUMNS) && row_r == RW'(ROWS - 1)) begin
                col_nxt = '0;
                st_nxt  = BK_PRIME;
              end else if (col_r == CW'(COLUMNS)) begin
                // wrap to the next row
                row_nxt  = row_r + RW'(1);
                base_nxt = base_r + AW'(COLUMNS);
                col_nxt  = CW'(1);
                we       = 1'b1;
                wa       = base_r + AW'(COLUMNS);
                wd       = glyph_now;
                emit     = 1'b1;
              end else begin
                col_nxt = col_r + CW'(1);
                we      = 1'b1;
                wa      = base_r + AW'(col_r);
                wd      = glyph_now;
                emit    = 1'b1;
              end
            end
            KIND_CLEAR: begin
              row_nxt  = '0;
              col_nxt  = '0;
              base_nxt = '0;
              ptr_nxt  = '0;
              st_nxt   = BK_SWEEP;
            end
            KIND_READ: begin
              rd_en  = cmd.idx_ok;
              ra     = AW'(cmd.index);
              st_nxt = BK_READ;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        out_val_nxt = cmd_r.idx_ok ? rdata_r : '0;
        emit        = 1'b1;
        st_nxt      = BK_IDLE;
      end
      BK_PRIME: begin
        // fetch the first cell of the second row
        rd_en   = 1'b1;
        ra      = AW'(COLUMNS);
        src_nxt = AW'(COLUMNS + 1);
        ptr_nxt = '0;
        st_nxt  = BK_SWEEP;
      end
      BK_SWEEP: begin
        // one cell a cycle: copy from the row below or blank
        we      = 1'b1;
        wa      = ptr_r;
        wd      = (scrolling && 32'(ptr_r) <= 32'(COPY_LAST)) ? rdata_r : blank;
        rd_en   = scrolling && (32'(ptr_r) < 32'(COPY_LAST));
        ra      = src_r;
        src_nxt = src_r + AW'(1);
        ptr_nxt = ptr_r + AW'(1);
        if (last_ptr) begin
          if (cmd_r.kind == KIND_PRINT) begin
            st_nxt = BK_PUT;
          end else begin
            emit   = 1'b1;
            st_nxt = BK_IDLE;
          end
        end
      end
      BK_PUT: begin
        we      = 1'b1;
        wa      = base_r;
        wd      = glyph_held;
        col_nxt = CW'(1);
        emit    = 1'b1;
        st_nxt  = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
    if (emit) out_valid_nxt = 1'b1;
    out_pos_nxt = POS_W'(pos_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_INIT;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    if (take) cmd_r <= cmd;
    if (emit) begin
      out_pos_r <= out_pos_nxt;
      out_val_r <= out_val_nxt;
    end
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rdata_r <= mem[ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - POS_W - CELL_W)'(0), out_val_r, out_pos_r};

  assign stat.init  = (st_r == BK_INIT);
  assign stat.take  = take;
  assign stat.sweep = (st_r == BK_PRIME) || (st_r == BK_SWEEP);

endmodule

### rtl/core/text_console_writer.sv
// Text console writer: ROWS x COLUMNS cell store with cursor, put-char/clear/read.
// Put-char without scroll, backspace and mode three answer from BK_IDLE; read via BK_READ;
// scroll via BK_PRIME, BK_SWEEP (and BK_PUT if a character follows); clear via BK_SWEEP.
// Throughput: one put-char a cycle while results are taken; scroll and clear hold off
// commands for the whole sweep. Reset (synchronous, active low): a clearing pass blanks
// the store to 0x0720 before the first item is carried out; registers are taken throughout.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: mode[1:0], char_code[9:2], cell_index[20:10]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: cursor_pos[10:0], cell_value[26:11]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]        cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  logic [ATTR_W-1:0] char_attr_r, blank_attr_r;
  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;
  bk_stat_t          stat;

  // Attribute registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_attr_r  <= RESET_CHAR_ATTR;
      blank_attr_r <= RESET_BLANK_ATTR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHAR_ATTR:  char_attr_r  <= cfg_wdata;
        REG_BLANK_ATTR: blank_attr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .char_attr  (char_attr_r),
    .blank_attr (blank_attr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

  // No command is carried out during the clearing pass
  a_no_take_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    stat.init |-> !stat.take)
    else $error("command taken during clearing pass");

  // A command is only started when the result register is free
  a_take_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    stat.take |-> (!out_tvalid || out_tready))
    else $error("command started over a pending result");

  // No result is pending while the store is being swept
  a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sweep |-> !out_tvalid)
    else $error("result pending during sweep");

  // Cursor never lies beyond the end of the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((CELLS >= 2048) || (32'(out_tdata[10:0]) <= 32'(CELLS))))
    else $error("cursor position out of range");

endmodule
